>>> design/rmrh_pkg.sv
// ----------------------------------------------------------------------------
// rmrh_pkg
// types and constants shared by the residue conversion and halving block
// ----------------------------------------------------------------------------
package rmrh_pkg;

  localparam int NUM_MODULI   = 4;
  localparam int RESIDUE_BITS = 16;
  localparam int NUM_CH       = 4;
  localparam int CH_W         = 2;
  localparam int SHIFT_W      = 6;
  localparam int CFG_W        = 48;
  localparam int CFG_IDX_W    = 3;
  localparam int PROD_W       = 2 * RESIDUE_BITS;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FIRST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SECOND = 3'd5;

  typedef logic [RESIDUE_BITS-1:0] res_t;

  typedef struct packed {
    logic               kind;
    res_t               residue_0;
    res_t               residue_1;
    res_t               residue_2;
    res_t               residue_3;
    logic [SHIFT_W-1:0] shift;
  } in_t;

  typedef struct packed {
    res_t out_0;
    res_t out_1;
    res_t out_2;
    res_t out_3;
    logic input_parity;
  } out_t;

  // request to the shared reduction unit
  typedef struct packed {
    logic              start;
    logic              long_op;
    logic [PROD_W-1:0] num;
    res_t              q;
  } red_req_t;

  typedef struct packed {
    logic done;
    res_t rem;
  } red_rsp_t;

endpackage

>>> design/rmrh_modred.sv
// ----------------------------------------------------------------------------
// rmrh_modred
// bit-serial remainder unit: one quotient bit per cycle, 16 or 32 bit dividend
// ----------------------------------------------------------------------------
module rmrh_modred (
  input  logic              clk,
  input  logic              rst_n,
  input  rmrh_pkg::red_req_t req,
  output rmrh_pkg::red_rsp_t rsp
);
  import rmrh_pkg::*;

  logic [PROD_W-1:0]   num_r;
  res_t                rem_r;
  res_t                q_r;
  logic [4:0]          cnt_r;
  logic                run_r;
  logic                done_r;
  logic [RESIDUE_BITS:0] trial;
  logic [RESIDUE_BITS:0] step_rem;

  always_comb begin
    trial = {rem_r, num_r[PROD_W-1]};
    if (trial >= {1'b0, q_r}) begin
      step_rem = trial - {1'b0, q_r};
    end else begin
      step_rem = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        rem_r <= '0;
        q_r   <= req.q;
        if (req.long_op) begin
          num_r <= req.num;
          cnt_r <= 5'(PROD_W - 1);
        end else begin
          // short operand sits in the upper half
          num_r <= {req.num[RESIDUE_BITS-1:0], {RESIDUE_BITS{1'b0}}};
          cnt_r <= 5'(RESIDUE_BITS - 1);
        end
      end else if (run_r) begin
        rem_r <= step_rem[RESIDUE_BITS-1:0];
        num_r <= {num_r[PROD_W-2:0], 1'b0};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

>>> design/rns_mixed_radix_halving.sv
// ----------------------------------------------------------------------------
// rns_mixed_radix_halving
// mixed-radix conversion and division by a power of two in residue form
// ----------------------------------------------------------------------------
// One transaction at a time: busy is high from the accepting edge until the
// result strobe. All modular work runs through one bit-serial remainder unit
// (one bit per cycle, 16-bit operands and 32-bit products), so that unit
// sets the latency. Kind 1 adds a halving and a fresh conversion per shift
// step after the first conversion.
// The result is shown for one cycle on out_item with out_strobe and must be
// taken then; a new transaction can be accepted in that same cycle.
module rns_mixed_radix_halving (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  rmrh_pkg::in_t                  in_item,
  output logic                           out_strobe,
  output rmrh_pkg::out_t                 out_item,
  input  logic                           cfg_we,
  input  logic [rmrh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rmrh_pkg::CFG_W-1:0]     cfg_data
);
  import rmrh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RX, S_RXW, S_KINIT, S_DJ, S_DJW, S_C, S_CW, S_MUL, S_P, S_PW,
    S_KDONE, S_CHECK
  } state_t;

  state_t state_r;

  res_t               mod_r [NUM_CH];
  logic [CFG_W-1:0]   inv1_r;
  logic [CFG_W-1:0]   inv2_r;

  res_t               x_r [NUM_CH];
  res_t               d_r [NUM_CH];
  res_t               a_r, dj_r, c_r;
  logic [PROD_W-1:0]  prod_r;
  logic [CH_W-1:0]    ch_r, k_r, j_r;
  logic               kind_r;
  logic [SHIFT_W-1:0] shift_r, cnt_r;
  logic               first_r, par_r;
  logic               strobe_r;
  out_t               out_r;

  red_req_t           req;
  red_rsp_t           rsp;

  res_t               qk;
  res_t               qch;
  res_t               inv_sel;
  logic [RESIDUE_BITS:0] diff;
  res_t               diff_red;
  logic               par;
  res_t               halved [NUM_CH];

  function automatic res_t eff_mod(input res_t m);
    return (m == '0) ? res_t'(1) : m;
  endfunction

  // inverse of modulus j modulo modulus k, j below k
  function automatic res_t inv_pick(input logic [CH_W-1:0] j, input logic [CH_W-1:0] k,
                                    input logic [CFG_W-1:0] w1, input logic [CFG_W-1:0] w2);
    logic [CH_W-1:0] pos;
    res_t            r;
    pos = '0;
    r   = '0;
    case (j)
      2'd0: begin
        pos = k - 2'd1;
        r   = w1[16*pos +: 16];
      end
      2'd1: begin
        pos = k - 2'd2;
        r   = w2[16*pos +: 16];
      end
      default: begin
        r = w2[32 +: 16];
      end
    endcase
    return r;
  endfunction

  rmrh_modred u_red (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    qk      = eff_mod(mod_r[k_r]);
    qch     = eff_mod(mod_r[ch_r]);
    inv_sel = inv_pick(j_r, k_r, inv1_r, inv2_r);
    diff    = {1'b0, a_r} + {1'b0, qk} - {1'b0, dj_r};
    if (diff >= {1'b0, qk}) begin
      diff_red = res_t'(diff - {1'b0, qk});
    end else begin
      diff_red = diff[RESIDUE_BITS-1:0];
    end
    par = 1'b0;
    for (int i = 0; i < NUM_MODULI; i++) begin
      par = par ^ d_r[i][0];
    end
  end

  // one halving step on every channel, parity from the conversion just done
  always_comb begin
    res_t                  q;
    res_t                  v;
    logic [RESIDUE_BITS:0] w;
    for (int i = 0; i < NUM_CH; i++) begin
      q = eff_mod(mod_r[i]);
      v = x_r[i];
      if (par) begin
        v = (v == '0) ? q - res_t'(1) : v - res_t'(1);
      end
      if (v[0]) begin
        w = {1'b0, v} + {1'b0, q};
      end else begin
        w = {1'b0, v};
      end
      halved[i] = (i < NUM_MODULI) ? w[RESIDUE_BITS:1] : '0;
    end
  end

  always_comb begin
    req = '0;
    case (state_r)
      S_RX: begin
        req.start = 1'b1;
        req.num   = PROD_W'(x_r[ch_r]);
        req.q     = qch;
      end
      S_DJ: begin
        req.start = 1'b1;
        req.num   = PROD_W'(d_r[j_r]);
        req.q     = qk;
      end
      S_C: begin
        req.start = 1'b1;
        req.num   = PROD_W'(inv_sel);
        req.q     = qk;
      end
      S_P: begin
        req.start   = 1'b1;
        req.long_op = 1'b1;
        req.num     = prod_r;
        req.q       = qk;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r[0] <= res_t'(3);
      mod_r[1] <= res_t'(5);
      mod_r[2] <= res_t'(7);
      mod_r[3] <= res_t'(11);
      inv1_r   <= CFG_W'(64'd17180196866);
      inv2_r   <= CFG_W'(64'd34360328195);
    end else if (cfg_we) begin
      if (cfg_index < CFG_IDX_W'(NUM_CH)) begin
        mod_r[cfg_index[CH_W-1:0]] <= cfg_data[RESIDUE_BITS-1:0];
      end else if (cfg_index == REG_INV_FIRST) begin
        inv1_r <= cfg_data;
      end else if (cfg_index == REG_INV_SECOND) begin
        inv2_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            x_r[0]  <= in_item.residue_0;
            x_r[1]  <= (NUM_MODULI > 1) ? in_item.residue_1 : '0;
            x_r[2]  <= (NUM_MODULI > 2) ? in_item.residue_2 : '0;
            x_r[3]  <= (NUM_MODULI > 3) ? in_item.residue_3 : '0;
            for (int i = 0; i < NUM_CH; i++) begin
              d_r[i] <= '0;
            end
            kind_r  <= in_item.kind;
            shift_r <= in_item.shift;
            cnt_r   <= '0;
            first_r <= 1'b1;
            ch_r    <= '0;
            state_r <= S_RX;
          end
        end
        S_RX: state_r <= S_RXW;
        S_RXW: begin
          if (rsp.done) begin
            x_r[ch_r] <= rsp.rem;
            if (ch_r == CH_W'(NUM_MODULI - 1)) begin
              k_r     <= '0;
              state_r <= S_KINIT;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_RX;
            end
          end
        end
        S_KINIT: begin
          a_r     <= x_r[k_r];
          j_r     <= '0;
          state_r <= (k_r == '0) ? S_KDONE : S_DJ;
        end
        S_DJ: state_r <= S_DJW;
        S_DJW: begin
          if (rsp.done) begin
            dj_r    <= rsp.rem;
            state_r <= S_C;
          end
        end
        S_C: state_r <= S_CW;
        S_CW: begin
          if (rsp.done) begin
            c_r     <= rsp.rem;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= diff_red * c_r;
          state_r <= S_P;
        end
        S_P: state_r <= S_PW;
        S_PW: begin
          if (rsp.done) begin
            a_r <= rsp.rem;
            if (j_r == k_r - 1'b1) begin
              state_r <= S_KDONE;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_DJ;
            end
          end
        end
        S_KDONE: begin
          d_r[k_r] <= a_r;
          if (k_r == CH_W'(NUM_MODULI - 1)) begin
            state_r <= S_CHECK;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_KINIT;
          end
        end
        S_CHECK: begin
          first_r <= 1'b0;
          if (first_r) begin
            par_r <= par;
          end
          if (!kind_r || cnt_r == shift_r) begin
            out_r.out_0        <= kind_r ? x_r[0] : d_r[0];
            out_r.out_1        <= kind_r ? x_r[1] : d_r[1];
            out_r.out_2        <= kind_r ? x_r[2] : d_r[2];
            out_r.out_3        <= kind_r ? x_r[3] : d_r[3];
            out_r.input_parity <= first_r ? par : par_r;
            strobe_r           <= 1'b1;
            state_r            <= S_IDLE;
          end else begin
            for (int i = 0; i < NUM_CH; i++) begin
              x_r[i] <= halved[i];
            end
            cnt_r   <= cnt_r + 1'b1;
            k_r     <= '0;
            state_r <= S_KINIT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

>>> design/rmrh_checker.sv
// ----------------------------------------------------------------------------
// rmrh_checker
// port-level checks on the transaction sequencing of the top level
// ----------------------------------------------------------------------------
module rmrh_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // a result only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without transaction");

  // result is one cycle wide and the block is free when it shows
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy ##1 !out_strobe)
    else $error("result strobe malformed");

endmodule

bind rns_mixed_radix_halving rmrh_checker u_rmrh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the residue conversion and halving block against its own predictor
// ----------------------------------------------------------------------------
// Directed transactions cover field extremes, both kinds, shift of zero and
// of 63, and residues at or above the modulus. Random transactions follow
// under several register settings: small and large prime moduli, a zero
// modulus, even moduli and extreme inverse words. Each result is compared
// field by field with the oldest expected result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmrh_pkg::*;

  localparam logic KIND_DIGITS = 1'b0;
  localparam logic KIND_DIVIDE = 1'b1;

  // indexes past the register list, writes to them are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  class rmrh_scoreboard;
    logic [15:0] modulus [4];
    logic [47:0] inv_first;
    logic [47:0] inv_second;
    out_t        expected_q [$];
    int          errors;
    int          checked;
    int          divides;

    function void reset_regs();
      modulus[0] = 16'd3;
      modulus[1] = 16'd5;
      modulus[2] = 16'd7;
      modulus[3] = 16'd11;
      inv_first  = 48'd17180196866;
      inv_second = 48'd34360328195;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] value);
      case (idx)
        REG_MODULUS_0, REG_MODULUS_1, REG_MODULUS_2, REG_MODULUS_3: begin
          modulus[idx[1:0]] = value[15:0];
        end
        REG_INV_FIRST:  inv_first  = value;
        REG_INV_SECOND: inv_second = value;
        default: ;
      endcase
    endfunction

    // a zero modulus makes the channel work modulo 1
    function longint unsigned eff_mod(int i);
      return (modulus[i] == 16'd0) ? 1 : longint'(modulus[i]);
    endfunction

    function longint unsigned inv_of(int j, int k);
      logic [47:0] w;
      int          pos;
      if (j == 0) begin
        w = inv_first; pos = k - 1;
      end else if (j == 1) begin
        w = inv_second; pos = k - 2;
      end else begin
        w = inv_second; pos = 2;
      end
      return longint'((w >> (16 * pos)) & 48'hFFFF);
    endfunction

    function void mixed_radix(input longint unsigned x [4], output longint unsigned d [4]);
      longint unsigned q, a, dj, c;
      for (int k = 0; k < 4; k++) begin
        q = eff_mod(k);
        a = x[k] % q;
        for (int j = 0; j < k; j++) begin
          dj = d[j] % q;
          c  = inv_of(j, k) % q;
          a  = ((a + q - dj) % q) * c % q;
        end
        d[k] = a;
      end
    endfunction

    function logic digit_parity(longint unsigned d [4]);
      logic p;
      p = 1'b0;
      for (int i = 0; i < 4; i++) p ^= d[i][0];
      return p;
    endfunction

    function void halve(inout longint unsigned x [4]);
      longint unsigned d [4];
      longint unsigned q, v;
      logic            odd;
      mixed_radix(x, d);
      odd = digit_parity(d);
      for (int i = 0; i < 4; i++) begin
        q = eff_mod(i);
        v = x[i];
        if (odd) v = (v == 0) ? q - 1 : v - 1;
        if (v[0]) v = (v + q) >> 1;
        else v = v >> 1;
        x[i] = v;
      end
    endfunction

    function void note_input(in_t it);
      longint unsigned x [4];
      longint unsigned d [4];
      out_t            e;
      x[0] = it.residue_0 % eff_mod(0);
      x[1] = it.residue_1 % eff_mod(1);
      x[2] = it.residue_2 % eff_mod(2);
      x[3] = it.residue_3 % eff_mod(3);
      mixed_radix(x, d);
      e.input_parity = digit_parity(d);
      if (it.kind == KIND_DIVIDE) begin
        divides++;
        for (int n = 0; n < it.shift; n++) halve(x);
        d = x;
      end
      e.out_0 = d[0][15:0];
      e.out_1 = d[1][15:0];
      e.out_2 = d[2][15:0];
      e.out_3 = d[3][15:0];
      expected_q = {expected_q, e};
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, got);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.out_0 !== e.out_0)
        $display("%0t: out_0 expected %0d actual %0d", $realtime, e.out_0, got.out_0);
      if (got.out_1 !== e.out_1)
        $display("%0t: out_1 expected %0d actual %0d", $realtime, e.out_1, got.out_1);
      if (got.out_2 !== e.out_2)
        $display("%0t: out_2 expected %0d actual %0d", $realtime, e.out_2, got.out_2);
      if (got.out_3 !== e.out_3)
        $display("%0t: out_3 expected %0d actual %0d", $realtime, e.out_3, got.out_3);
      if (got.input_parity !== e.input_parity)
        $display("%0t: input_parity expected %0b actual %0b", $realtime,
                 e.input_parity, got.input_parity);
      if (got !== e) errors++;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  in_t                in_item = '0;
  logic               out_strobe;
  out_t               out_item;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  rmrh_scoreboard sb;
  int burst_left;
  int big_shifts;

  rns_mixed_radix_halving dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  // called right after a rising edge; returns right after the accepting edge, or after an idle gap when a burst ends
  task automatic issue(in_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 600)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic longint unsigned mod_inverse(longint unsigned a, longint unsigned m);
    longint r0, r1, t0, t1, qt, tmp;
    r0 = m; r1 = a % m; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      tmp = r0 - qt * r1; r0 = r1; r1 = tmp;
      tmp = t0 - qt * t1; t0 = t1; t1 = tmp;
    end
    if (t0 < 0) t0 += m;
    return t0;
  endfunction

  task automatic load_moduli(logic [15:0] m0, logic [15:0] m1, logic [15:0] m2,
                             logic [15:0] m3);
    logic [47:0] w1, w2;
    logic [15:0] i01, i02, i03, i12, i13, i23;
    i01 = 16'(mod_inverse(64'(m0), 64'(m1)));
    i02 = 16'(mod_inverse(64'(m0), 64'(m2)));
    i03 = 16'(mod_inverse(64'(m0), 64'(m3)));
    i12 = 16'(mod_inverse(64'(m1), 64'(m2)));
    i13 = 16'(mod_inverse(64'(m1), 64'(m3)));
    i23 = 16'(mod_inverse(64'(m2), 64'(m3)));
    w1 = {i03, i02, i01};
    w2 = {i23, i13, i12};
    write_reg(REG_MODULUS_0, 48'(m0));
    write_reg(REG_MODULUS_1, 48'(m1));
    write_reg(REG_MODULUS_2, 48'(m2));
    write_reg(REG_MODULUS_3, 48'(m3));
    write_reg(REG_INV_FIRST, w1);
    write_reg(REG_INV_SECOND, w2);
  endtask

  function automatic logic [15:0] pick_residue(int ch);
    longint unsigned m;
    m = sb.eff_mod(ch);
    if ($urandom_range(0, 1) == 0) return 16'($urandom);
    return 16'($urandom_range(0, int'(m - 1)));
  endfunction

  function automatic in_t random_item();
    in_t it;
    int  r;
    it.kind      = 1'($urandom);
    it.residue_0 = pick_residue(0);
    it.residue_1 = pick_residue(1);
    it.residue_2 = pick_residue(2);
    it.residue_3 = pick_residue(3);
    r = $urandom_range(0, 99);
    // long divisions are slow, so only a capped number of them
    if (r < 2 && big_shifts < 20) begin
      it.shift = 6'($urandom_range(13, 63));
      if (it.kind == KIND_DIVIDE) big_shifts++;
    end else if (r < 30) begin
      it.shift = 6'($urandom_range(5, 12));
    end else begin
      it.shift = 6'($urandom_range(0, 4));
    end
    // kind 0 ignores the shift, so any bits may go there
    if (it.kind == KIND_DIGITS && $urandom_range(0, 3) == 0) it.shift = 6'($urandom);
    return it;
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) issue(random_item());
    drain();
  endtask

  task automatic directed_phase();
    in_t it;
    it = '{KIND_DIGITS, 16'd0, 16'd0, 16'd0, 16'd0, 6'd0};       issue(it);
    it = '{KIND_DIGITS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'h3F}; issue(it);
    it = '{KIND_DIGITS, 16'd2, 16'd4, 16'd6, 16'd10, 6'd0};      issue(it);
    it = '{KIND_DIGITS, 16'd3, 16'd5, 16'd7, 16'd11, 6'd0};      issue(it);
    it = '{KIND_DIVIDE, 16'd1, 16'd1, 16'd1, 16'd1, 6'd0};       issue(it);
    it = '{KIND_DIVIDE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0}; issue(it);
    it = '{KIND_DIVIDE, 16'd1, 16'd1, 16'd1, 16'd1, 6'd1};       issue(it);
    it = '{KIND_DIVIDE, 16'd2, 16'd4, 16'd6, 16'd10, 6'd1};      issue(it);
    it = '{KIND_DIVIDE, 16'd0, 16'd0, 16'd0, 16'd0, 6'd1};       issue(it);
    it = '{KIND_DIVIDE, 16'd2, 16'd4, 16'd6, 16'd10, 6'h3F};     issue(it);
    it = '{KIND_DIVIDE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'h3F}; issue(it);
    it = '{KIND_DIVIDE, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 6'h2A}; issue(it);
    it = '{KIND_DIVIDE, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 6'h15}; issue(it);
    it = '{KIND_DIGITS, 16'd1, 16'd0, 16'd0, 16'd0, 6'd0};       issue(it);
    it = '{KIND_DIVIDE, 16'd0, 16'd0, 16'd0, 16'd1, 6'd2};       issue(it);
    drain();
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    burst_left = 0;
    big_shifts = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_phase();
    random_phase(300);

    load_moduli(16'd65479, 16'd65497, 16'd65519, 16'd65521);
    directed_phase();
    random_phase(300);

    // zero modulus, even moduli and extreme inverse words
    write_reg(REG_MODULUS_0, 48'd0);
    write_reg(REG_MODULUS_1, 48'hFFFF);
    write_reg(REG_MODULUS_2, 48'd4);
    write_reg(REG_MODULUS_3, 48'd65534);
    write_reg(REG_INV_FIRST, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_INV_SECOND, 48'h0);
    write_reg(REG_UNUSED_6, 48'h1234_5678_9ABC);
    write_reg(REG_UNUSED_7, 48'hFFFF_FFFF_FFFF);
    directed_phase();
    random_phase(250);

    write_reg(REG_INV_FIRST, 48'h0);
    write_reg(REG_INV_SECOND, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_MODULUS_0, 48'd1);
    random_phase(150);

    load_moduli(16'd13, 16'd17, 16'd19, 16'd23);
    random_phase(250);

    load_moduli(16'd3, 16'd5, 16'd7, 16'd11);
    random_phase(200);

    $display("checked %0d results, %0d of them divisions, under six register settings",
             sb.checked, sb.divides);
    $display("%0d long divisions, %0d mismatching results", big_shifts, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
design/rmrh_pkg.sv
design/rmrh_modred.sv
design/rns_mixed_radix_halving.sv
design/rmrh_checker.sv
tb/tb_top.sv
